// ----- hw/rtl/swic_pkg.sv -----
// shared constants, control word layout and microcode rom for the
// sliding window inversion counter; no dependencies
package swic_pkg;

   // sizes of the value space and of the window
   localparam int VALUE_BITS = 10;
   localparam int WINDOW_MAX = 1024;

   // port widths fixed by the interface
   localparam int WS_BITS  = 11;
   localparam int INV_BITS = 19;

   // derived sizes
   localparam int TREE_SIZE  = 1 << VALUE_BITS;
   localparam int IDX_BITS   = VALUE_BITS + 2;
   localparam int CNT_BITS   = $clog2(WINDOW_MAX + 1);
   localparam int RING_AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int TOTAL_BITS =
      $clog2(longint'(WINDOW_MAX) * longint'(WINDOW_MAX - 1) / 2 + 1) + 1;

   // program counter and step addresses
   localparam int PC_BITS = 4;
   localparam logic [PC_BITS-1:0] PC_IDLE    = 4'd0;
   localparam logic [PC_BITS-1:0] PC_QRY_NEW = 4'd1;
   localparam logic [PC_BITS-1:0] PC_ADD     = 4'd2;
   localparam logic [PC_BITS-1:0] PC_INS_RD  = 4'd3;
   localparam logic [PC_BITS-1:0] PC_INS_WR  = 4'd4;
   localparam logic [PC_BITS-1:0] PC_CHECK   = 4'd5;
   localparam logic [PC_BITS-1:0] PC_OLD     = 4'd6;
   localparam logic [PC_BITS-1:0] PC_QRY_OLD = 4'd7;
   localparam logic [PC_BITS-1:0] PC_SUB     = 4'd8;
   localparam logic [PC_BITS-1:0] PC_DEL_RD  = 4'd9;
   localparam logic [PC_BITS-1:0] PC_DEL_WR  = 4'd10;
   localparam logic [PC_BITS-1:0] PC_DONE    = 4'd11;
   localparam logic [PC_BITS-1:0] PC_CLEAR   = 4'd12;

   // sequencing modes
   typedef enum logic [2:0] {
      SEQ_NEXT,
      SEQ_JUMP,
      SEQ_WAIT_REQ,
      SEQ_LOOP_NZ,
      SEQ_EXIT_RANGE,
      SEQ_CHECK,
      SEQ_CLEAR
   } seq_op_type;

   // tree memory access
   typedef enum logic [2:0] {
      TREE_NONE,
      TREE_QUERY,
      TREE_READ,
      TREE_WRITE,
      TREE_CLEAR
   } tree_op_type;

   // fenwick index update
   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_SUB_LSB,
      IDX_ADD_LSB,
      IDX_VAL_INC,
      IDX_RING,
      IDX_OLD_INC
   } idx_op_type;

   // running total update
   typedef enum logic [1:0] {
      TOT_HOLD,
      TOT_ADD,
      TOT_SUB
   } tot_op_type;

   typedef struct packed {
      seq_op_type          seq;
      logic [PC_BITS-1:0]  target;
      tree_op_type         tree_op;
      idx_op_type          idx_op;
      tot_op_type          tot_op;
      logic                load_req;
      logic                acc_clr;
      logic                delta_neg;
      logic                ring_rd;
      logic                old_load;
      logic                seen_done;
   } ucode_word_type;

   localparam ucode_word_type UC_NOP = '{
      seq: SEQ_JUMP, target: PC_IDLE, tree_op: TREE_NONE, idx_op: IDX_HOLD,
      tot_op: TOT_HOLD, load_req: 1'b0, acc_clr: 1'b0, delta_neg: 1'b0,
      ring_rd: 1'b0, old_load: 1'b0, seen_done: 1'b0};

   // microcode program
   function automatic ucode_word_type ucode_rom(input logic [PC_BITS-1:0] pc);
      ucode_word_type w;
      w = UC_NOP;
      case (pc)
         PC_IDLE: begin
            w.seq      = SEQ_WAIT_REQ;
            w.target   = PC_QRY_NEW;
            w.load_req = 1'b1;
         end
         PC_QRY_NEW: begin
            w.seq     = SEQ_LOOP_NZ;
            w.tree_op = TREE_QUERY;
            w.idx_op  = IDX_SUB_LSB;
         end
         PC_ADD: begin
            w.seq    = SEQ_NEXT;
            w.tot_op = TOT_ADD;
            w.idx_op = IDX_VAL_INC;
         end
         PC_INS_RD: begin
            w.seq     = SEQ_EXIT_RANGE;
            w.target  = PC_CHECK;
            w.tree_op = TREE_READ;
         end
         PC_INS_WR: begin
            w.seq     = SEQ_JUMP;
            w.target  = PC_INS_RD;
            w.tree_op = TREE_WRITE;
            w.idx_op  = IDX_ADD_LSB;
         end
         PC_CHECK: begin
            w.seq     = SEQ_CHECK;
            w.target  = PC_IDLE;
            w.ring_rd = 1'b1;
         end
         PC_OLD: begin
            w.seq      = SEQ_NEXT;
            w.idx_op   = IDX_RING;
            w.acc_clr  = 1'b1;
            w.old_load = 1'b1;
         end
         PC_QRY_OLD: begin
            w.seq     = SEQ_LOOP_NZ;
            w.tree_op = TREE_QUERY;
            w.idx_op  = IDX_SUB_LSB;
         end
         PC_SUB: begin
            w.seq    = SEQ_NEXT;
            w.tot_op = TOT_SUB;
            w.idx_op = IDX_OLD_INC;
         end
         PC_DEL_RD: begin
            w.seq     = SEQ_EXIT_RANGE;
            w.target  = PC_DONE;
            w.tree_op = TREE_READ;
         end
         PC_DEL_WR: begin
            w.seq       = SEQ_JUMP;
            w.target    = PC_DEL_RD;
            w.tree_op   = TREE_WRITE;
            w.idx_op    = IDX_ADD_LSB;
            w.delta_neg = 1'b1;
         end
         PC_DONE: begin
            w.seq       = SEQ_JUMP;
            w.target    = PC_IDLE;
            w.seen_done = 1'b1;
         end
         PC_CLEAR: begin
            w.seq     = SEQ_CLEAR;
            w.target  = PC_IDLE;
            w.tree_op = TREE_CLEAR;
         end
         default: w = UC_NOP;
      endcase
      return w;
   endfunction

   // effective window length: zero counts as one, large values saturate
   function automatic logic [CNT_BITS-1:0] win_len(input logic [WS_BITS-1:0] ws);
      int w;
      w = int'(ws);
      if (w == 0) w = 1;
      if (w > WINDOW_MAX) w = WINDOW_MAX;
      return CNT_BITS'(w);
   endfunction

endpackage

// ----- hw/rtl/swic_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module swic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/sliding_window_inversion_count_core.sv -----
// sliding window inversion counter: fenwick tree of value counts and a ring of recent
// values in two rams, run by a microcoded sequencer; one word at a time.
// a result is sent only once the window is full, after the new value's tree query and
// insert; while the window fills, no result is sent. When full, the leaving value is then
// queried and removed from the tree before the next accept; uses swic_pkg, swic_ram.
// reset or csr write: tree clear pass; window_size is 1 after reset, the csr value after a write
module sliding_window_inversion_count_core
   import swic_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [INV_BITS-1:0] rsp_inversions,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [WS_BITS-1:0]  csr_window_size
);

   // control registers
   logic [PC_BITS-1:0]    pc_ff, pc_in;
   logic [VALUE_BITS-1:0] clr_ff, clr_in;
   logic [WS_BITS-1:0]    ws_ff, ws_in;
   logic [CNT_BITS-1:0]   seen_ff, seen_in;
   logic [RING_AW-1:0]    pos_ff, pos_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rd_vld_ff, rd_vld_in;

   // datapath registers
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [CNT_BITS-1:0]   acc_ff, acc_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [VALUE_BITS-1:0] old_ff, old_in;
   logic [INV_BITS-1:0]   out_ff, out_in;

   ucode_word_type        cw;
   logic                  req_fire;
   logic                  csr_fire;
   logic [CNT_BITS-1:0]   win;
   logic [CNT_BITS-1:0]   held;
   logic                  full;
   logic                  out_free;
   logic                  check_go;
   logic [IDX_BITS-1:0]   lsb;
   logic                  idx_nz;
   logic                  idx_in_range;
   logic [VALUE_BITS-1:0] tree_addr;
   logic                  tree_wr_en;
   logic [VALUE_BITS-1:0] tree_wr_addr;
   logic [CNT_BITS-1:0]   tree_wr_data;
   logic                  tree_rd_en;
   logic [CNT_BITS-1:0]   tree_rd_data;
   logic [CNT_BITS-1:0]   delta;
   logic [RING_AW:0]      oldest_sum;
   logic [RING_AW-1:0]    oldest_slot;
   logic [VALUE_BITS-1:0] ring_rd_data;

   // control word of the current step
   assign cw = ucode_rom(pc_ff);

   assign req_ready = (pc_ff == PC_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;

   // window bookkeeping
   assign win      = win_len(ws_ff);
   assign held     = seen_ff + CNT_BITS'(1);
   assign full     = (held >= win);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign check_go = (cw.seq == SEQ_CHECK) && (!full || out_free);

   // fenwick index helpers
   assign lsb          = idx_ff & (~idx_ff + IDX_BITS'(1));
   assign idx_nz       = (idx_ff != '0);
   assign idx_in_range = idx_nz && (idx_ff <= IDX_BITS'(TREE_SIZE));
   assign tree_addr    = VALUE_BITS'(idx_ff - IDX_BITS'(1));

   // slot of the value leaving the window
   assign oldest_sum  = {1'b0, pos_ff} + (RING_AW+1)'(WINDOW_MAX)
                        - (RING_AW+1)'(seen_ff);
   assign oldest_slot = (oldest_sum >= (RING_AW+1)'(WINDOW_MAX))
                        ? RING_AW'(oldest_sum - (RING_AW+1)'(WINDOW_MAX))
                        : RING_AW'(oldest_sum);

   // tree memory port control
   assign delta        = cw.delta_neg ? '1 : CNT_BITS'(1);
   assign tree_rd_en   = ((cw.tree_op == TREE_QUERY) && idx_nz)
                         || (cw.tree_op == TREE_READ);
   assign tree_wr_en   = (cw.tree_op == TREE_WRITE) || (cw.tree_op == TREE_CLEAR);
   assign tree_wr_addr = (cw.tree_op == TREE_CLEAR) ? clr_ff : tree_addr;
   assign tree_wr_data = (cw.tree_op == TREE_CLEAR) ? '0 : tree_rd_data + delta;

   swic_ram #(
      .WIDTH (CNT_BITS),
      .DEPTH (TREE_SIZE)
   ) u_tree (
      .clock   (clock),
      .wr_en   (tree_wr_en),
      .wr_addr (tree_wr_addr),
      .wr_data (tree_wr_data),
      .rd_en   (tree_rd_en),
      .rd_addr (tree_addr),
      .rd_data (tree_rd_data)
   );

   swic_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (pos_ff),
      .wr_data (req_value),
      .rd_en   (cw.ring_rd),
      .rd_addr (oldest_slot),
      .rd_data (ring_rd_data)
   );

   // sequencer
   always_comb begin
      pc_in  = pc_ff;
      clr_in = clr_ff;
      case (cw.seq)
         SEQ_NEXT:       pc_in = PC_BITS'(pc_ff + PC_BITS'(1));
         SEQ_JUMP:       pc_in = cw.target;
         SEQ_WAIT_REQ:   pc_in = req_valid ? cw.target : pc_ff;
         SEQ_LOOP_NZ:    pc_in = idx_nz ? pc_ff : PC_BITS'(pc_ff + PC_BITS'(1));
         SEQ_EXIT_RANGE: pc_in = idx_in_range ? PC_BITS'(pc_ff + PC_BITS'(1))
                                              : cw.target;
         SEQ_CHECK: begin
            if (!full) begin
               pc_in = cw.target;
            end else if (out_free) begin
               pc_in = PC_BITS'(pc_ff + PC_BITS'(1));
            end
         end
         SEQ_CLEAR: begin
            clr_in = clr_ff + VALUE_BITS'(1);
            if (clr_ff == VALUE_BITS'(TREE_SIZE - 1)) begin
               pc_in = cw.target;
            end
         end
         default: pc_in = PC_IDLE;
      endcase
      // a csr write restarts the stream with a fresh clearing pass
      if (csr_fire) begin
         pc_in  = PC_CLEAR;
         clr_in = '0;
      end
   end

   // datapath next values
   always_comb begin
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      val_in       = val_ff;
      old_in       = old_ff;
      out_in       = out_ff;
      total_in     = total_ff;
      seen_in      = seen_ff;
      pos_in       = pos_ff;
      ws_in        = ws_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_vld_in    = (cw.tree_op == TREE_QUERY) && idx_nz;

      // accumulate query reads in the cycle after issue
      if (rd_vld_ff) begin
         acc_in = acc_ff + tree_rd_data;
      end

      // word accepted
      if (cw.load_req && req_fire) begin
         val_in = req_value;
         idx_in = IDX_BITS'(req_value) + IDX_BITS'(1);
         acc_in = '0;
      end

      if (cw.acc_clr) begin
         acc_in = '0;
      end
      if (cw.old_load) begin
         old_in = ring_rd_data;
      end

      // index stepping
      case (cw.idx_op)
         IDX_HOLD:    idx_in = idx_in;
         IDX_SUB_LSB: begin
            if (idx_nz) begin
               idx_in = idx_ff - lsb;
            end
         end
         IDX_ADD_LSB: idx_in = idx_ff + lsb;
         IDX_VAL_INC: idx_in = IDX_BITS'(val_ff) + IDX_BITS'(1);
         IDX_RING:    idx_in = IDX_BITS'(ring_rd_data);
         IDX_OLD_INC: idx_in = IDX_BITS'(old_ff) + IDX_BITS'(1);
         default:     idx_in = idx_ff;
      endcase

      // running total
      case (cw.tot_op)
         TOT_HOLD: total_in = total_ff;
         TOT_ADD:  total_in = total_ff + TOTAL_BITS'(seen_ff) - TOTAL_BITS'(acc_ff);
         TOT_SUB:  total_in = total_ff - TOTAL_BITS'(acc_ff);
         default:  total_in = total_ff;
      endcase

      // window check, result and ring advance
      if (check_go) begin
         pos_in = (pos_ff == RING_AW'(WINDOW_MAX - 1)) ? '0
                                                       : RING_AW'(pos_ff + RING_AW'(1));
         if (full) begin
            out_in       = INV_BITS'(total_ff);
            rsp_valid_in = 1'b1;
         end else begin
            seen_in = held;
         end
      end

      if (cw.seen_done) begin
         seen_in = win - CNT_BITS'(1);
      end

      // csr write restarts the stream
      if (csr_fire) begin
         ws_in    = csr_window_size;
         seen_in  = '0;
         pos_in   = '0;
         total_in = '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_CLEAR;
         clr_ff       <= '0;
         ws_ff        <= WS_BITS'(1);
         seen_ff      <= '0;
         pos_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         clr_ff       <= clr_in;
         ws_ff        <= ws_in;
         seen_ff      <= seen_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      acc_ff <= acc_in;
      val_ff <= val_in;
      old_ff <= old_in;
      out_ff <= out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inversions = out_ff;

endmodule
